>>> rtl/cddp_pkg.sv
// package: register indexes, reset values and fixed constants of the drive controller
`default_nettype none
package cddp_pkg;

  localparam int FracBitsDef  = 8;
  localparam int GainWidthDef = 16;

  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 48;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OUTER_KP    = 8'd0,
    REG_OUTER_KD    = 8'd1,
    REG_RATE_KP     = 8'd2,
    REG_RATE_KD     = 8'd3,
    REG_WHEEL_GAINS = 8'd4,
    REG_DRIVE_MAX   = 8'd5,
    REG_DRIVE_MIN   = 8'd6,
    REG_SPEED_LVLS  = 8'd7
  } cfg_reg_e;

  localparam logic signed [15:0] DriveMaxRst = 16'sd9999;
  localparam logic signed [15:0] DriveMinRst = -16'sd9999;

  localparam int RateLimit  = 140;
  localparam int TargetLow  = -10;
  localparam int TargetHigh = 120;

  typedef struct packed {
    logic issue;
    logic clr;
  } mac_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/cddp_mac.sv
// shared multiply-accumulate unit: registered product, then accumulate
`default_nettype none
module cddp_mac #(
  parameter int OPW = 27,
  parameter int GW  = 16,
  parameter int AW  = 46
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire cddp_pkg::mac_ctrl_t    ctrl_i,
  input  wire logic signed [OPW-1:0]  a_i,
  input  wire logic        [GW-1:0]   b_i,
  output logic signed [AW-1:0]        acc_o
);

  localparam int PW = OPW + GW + 1;

  logic signed [PW-1:0] prod_q;
  logic                 vld_q;
  logic                 clr_q;
  logic signed [AW-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      clr_q <= 1'b0;
    end else begin
      vld_q <= ctrl_i.issue;
      clr_q <= ctrl_i.clr;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * $signed({1'b0, b_i});
    if (vld_q) begin
      acc_q <= (clr_q ? '0 : acc_q) + AW'(prod_q);
    end
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

>>> rtl/cascaded_differential_drive_pid.sv
// top level: cascaded heading/yaw-rate pd and two incremental wheel pids on one mac
//
//  channel   dir  handshake                 contents
//  s_axis    in   s_axis_tvalid/tready      tdata: heading, yaw, left, right speed
//  m_axis    out  m_axis_tvalid/tready      tdata: left drive, right drive
//  cfg       in   cfg_valid_i/cfg_ready_o   register index, write data
//
//  one request runs ten multiplies, issued one per cycle to the single mac and
//  summed through its registered product and accumulator for each loop stage.
//  s_axis_tready and cfg_ready_o are high only while the sequencer is idle, so a new
//  request is taken only once the previous one has left the sequencer; a finished
//  result waits in the output register and the next request is taken while it waits.
//  reset clears all loop history and gains; drive limits reset to +-9999.
`default_nettype none
module cascaded_differential_drive_pid #(
  parameter int FRAC_BITS  = cddp_pkg::FracBitsDef,
  parameter int GAIN_WIDTH = cddp_pkg::GainWidthDef
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // heading_error[15:0], yaw_rate[31:16], left_speed[47:32], right_speed[63:48]
  input  wire logic [63:0]                  s_axis_tdata,
  // curve_sel[0], straight_sel[1]
  input  wire logic [1:0]                   s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // left_drive[15:0], right_drive[31:16]
  output logic [31:0]                       m_axis_tdata,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [cddp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [cddp_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int F   = FRAC_BITS;
  localparam int GW  = GAIN_WIDTH;
  localparam int OPW = F + 19;
  localparam int AW  = OPW + GW + 3;

  typedef enum logic [3:0] {
    S_IDLE, S_O0, S_O1, S_O2, S_O3, S_M0, S_M1, S_M2, S_M3,
    S_W0, S_W1, S_W2, S_W3, S_W4, S_HOLD
  } state_e;

  state_e state_q;

  logic [15:0] okp_q, okd_q, rkp_q, rkd_q;
  logic [47:0] wg_q;
  logic signed [15:0] dmax_q, dmin_q;
  logic [23:0] lvl_q;

  logic signed [15:0] herr_q, yaw_q, lsp_q, rsp_q;
  logic bend_q, str_q;
  logic signed [15:0] oprev_q;
  logic signed [OPW-1:0] aerr_q, rprev_q;
  logic signed [16:0] err_q [2];
  logic signed [16:0] last_q [2];
  logic signed [16:0] prev_q [2];
  logic signed [AW-1:0] wout_q [2];
  logic signed [15:0] drv_q [2];
  logic k_q;
  logic out_vld_q;
  logic [31:0] out_q;

  logic [79:0] gpad;
  logic [GW-1:0] g_okp, g_okd, g_rkp, g_rkd, g_wkp, g_wki, g_wkd;
  assign gpad  = {32'd0, wg_q};
  assign g_okp = GW'({64'd0, okp_q} & ((80'd1 << GW) - 80'd1));
  assign g_okd = GW'({64'd0, okd_q} & ((80'd1 << GW) - 80'd1));
  assign g_rkp = GW'({64'd0, rkp_q} & ((80'd1 << GW) - 80'd1));
  assign g_rkd = GW'({64'd0, rkd_q} & ((80'd1 << GW) - 80'd1));
  assign g_wkp = gpad[0 +: GW];
  assign g_wki = gpad[16 +: GW];
  assign g_wkd = gpad[32 +: GW];

  cddp_pkg::mac_ctrl_t   mac_ctrl;
  logic signed [OPW-1:0] mac_a;
  logic [GW-1:0]         mac_b;
  logic signed [AW-1:0]  mac_acc;

  cddp_mac #(.OPW(OPW), .GW(GW), .AW(AW)) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (mac_acc)
  );

  logic signed [16:0] e_cur, l_cur, p_cur;
  assign e_cur = err_q[k_q];
  assign l_cur = last_q[k_q];
  assign p_cur = prev_q[k_q];

  always_comb begin
    mac_ctrl = '0;
    mac_a    = '0;
    mac_b    = '0;
    case (state_q)
      S_O0: begin
        mac_ctrl = '{issue: 1'b1, clr: 1'b1};
        mac_a = OPW'(herr_q);
        mac_b = g_okp;
      end
      S_O1: begin
        mac_ctrl = '{issue: 1'b1, clr: 1'b0};
        mac_a = OPW'(herr_q) - OPW'(oprev_q);
        mac_b = g_okd;
      end
      S_M0: begin
        mac_ctrl = '{issue: 1'b1, clr: 1'b1};
        mac_a = aerr_q;
        mac_b = g_rkp;
      end
      S_M1: begin
        mac_ctrl = '{issue: 1'b1, clr: 1'b0};
        mac_a = aerr_q - rprev_q;
        mac_b = g_rkd;
      end
      S_W0: begin
        mac_ctrl = '{issue: 1'b1, clr: 1'b1};
        mac_a = OPW'(e_cur) - OPW'(l_cur);
        mac_b = g_wkp;
      end
      S_W1: begin
        mac_ctrl = '{issue: 1'b1, clr: 1'b0};
        mac_a = OPW'(e_cur);
        mac_b = g_wki;
      end
      S_W2: begin
        mac_ctrl = '{issue: 1'b1, clr: 1'b0};
        mac_a = OPW'(e_cur) - (OPW'(l_cur) <<< 1) + OPW'(p_cur);
        mac_b = g_wkd;
      end
      default: begin
        mac_ctrl = '0;
      end
    endcase
  end

  // outer target clamp and rate error
  localparam logic signed [15:0] RateLimitS = 16'(cddp_pkg::RateLimit);
  logic signed [AW-1:0] rate_hi, rate_lo, target;
  logic signed [OPW-1:0] aerr_d;
  assign rate_hi = AW'(RateLimitS) <<< F;
  assign rate_lo = -(AW'(RateLimitS) <<< F);
  always_comb begin
    if (mac_acc > rate_hi) target = rate_hi;
    else if (mac_acc < rate_lo) target = rate_lo;
    else target = mac_acc;
  end
  assign aerr_d = OPW'(target) - (OPW'(yaw_q) <<< F);

  // wheel targets
  localparam logic signed [15:0] TgtLoS = 16'(cddp_pkg::TargetLow);
  localparam logic signed [15:0] TgtHiS = 16'(cddp_pkg::TargetHigh);
  logic signed [AW-1:0] diff, base_fx, t_lo, t_hi, tl_raw, tr_raw, tl_c, tr_c;
  logic signed [AW-1:0] tl_i, tr_i;
  logic [7:0] base;
  logic signed [16:0] el_d, er_d;
  assign diff    = mac_acc >>> F;
  assign base    = bend_q ? lvl_q[15:8] : (str_q ? lvl_q[23:16] : lvl_q[7:0]);
  assign base_fx = $signed(AW'(base)) <<< F;
  assign t_lo    = AW'(TgtLoS) <<< F;
  assign t_hi    = AW'(TgtHiS) <<< F;
  assign tl_raw  = base_fx - diff;
  assign tr_raw  = base_fx + diff;
  always_comb begin
    if (tl_raw > t_hi) tl_c = t_hi;
    else if (tl_raw < t_lo) tl_c = t_lo;
    else tl_c = tl_raw;
    if (tr_raw > t_hi) tr_c = t_hi;
    else if (tr_raw < t_lo) tr_c = t_lo;
    else tr_c = tr_raw;
  end
  assign tl_i = tl_c[AW-1] ? -((-tl_c) >>> F) : (tl_c >>> F);
  assign tr_i = tr_c[AW-1] ? -((-tr_c) >>> F) : (tr_c >>> F);
  assign el_d = 17'(tl_i) - 17'(lsp_q);
  assign er_d = 17'(tr_i) - 17'(rsp_q);

  // wheel accumulator saturation
  logic signed [AW-1:0] wsum, dmax_fx, dmin_fx, wsat, wtr;
  assign wsum    = wout_q[k_q] + mac_acc;
  assign dmax_fx = AW'(dmax_q) <<< F;
  assign dmin_fx = AW'(dmin_q) <<< F;
  always_comb begin
    if (wsum > dmax_fx) wsat = dmax_fx;
    else if (wsum < dmin_fx) wsat = dmin_fx;
    else wsat = wsum;
  end
  assign wtr = wsat[AW-1] ? -((-wsat) >>> F) : (wsat >>> F);

  logic s_acc, m_acc;
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_acc         = m_axis_tvalid && m_axis_tready;
  assign cfg_ready_o   = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      out_q     <= '0;
      k_q       <= 1'b0;
      okp_q <= '0; okd_q <= '0; rkp_q <= '0; rkd_q <= '0;
      wg_q  <= '0; lvl_q <= '0;
      dmax_q <= cddp_pkg::DriveMaxRst;
      dmin_q <= cddp_pkg::DriveMinRst;
      herr_q <= '0; yaw_q <= '0; lsp_q <= '0; rsp_q <= '0;
      bend_q <= 1'b0; str_q <= 1'b0;
      aerr_q  <= '0;
      oprev_q <= '0;
      rprev_q <= '0;
      err_q   <= '{default: '0};
      last_q  <= '{default: '0};
      prev_q  <= '{default: '0};
      wout_q  <= '{default: '0};
      drv_q   <= '{default: '0};
    end else begin
      if (m_acc && state_q != S_HOLD) out_vld_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          cddp_pkg::REG_OUTER_KP:    okp_q  <= cfg_data_i[15:0];
          cddp_pkg::REG_OUTER_KD:    okd_q  <= cfg_data_i[15:0];
          cddp_pkg::REG_RATE_KP:     rkp_q  <= cfg_data_i[15:0];
          cddp_pkg::REG_RATE_KD:     rkd_q  <= cfg_data_i[15:0];
          cddp_pkg::REG_WHEEL_GAINS: wg_q   <= cfg_data_i[47:0];
          cddp_pkg::REG_DRIVE_MAX:   dmax_q <= $signed(cfg_data_i[15:0]);
          cddp_pkg::REG_DRIVE_MIN:   dmin_q <= $signed(cfg_data_i[15:0]);
          cddp_pkg::REG_SPEED_LVLS:  lvl_q  <= cfg_data_i[23:0];
          default: begin
          end
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (s_acc) begin
            herr_q <= $signed(s_axis_tdata[15:0]);
            yaw_q  <= $signed(s_axis_tdata[31:16]);
            lsp_q  <= $signed(s_axis_tdata[47:32]);
            rsp_q  <= $signed(s_axis_tdata[63:48]);
            bend_q <= s_axis_tuser[0];
            str_q  <= s_axis_tuser[1];
            state_q <= S_O0;
          end
        end
        S_O0: state_q <= S_O1;
        S_O1: state_q <= S_O2;
        S_O2: state_q <= S_O3;
        S_O3: begin
          aerr_q  <= aerr_d;
          oprev_q <= herr_q;
          state_q <= S_M0;
        end
        S_M0: state_q <= S_M1;
        S_M1: state_q <= S_M2;
        S_M2: state_q <= S_M3;
        S_M3: begin
          rprev_q  <= aerr_q;
          err_q[0] <= el_d;
          err_q[1] <= er_d;
          k_q      <= 1'b0;
          state_q  <= S_W0;
        end
        S_W0: state_q <= S_W1;
        S_W1: state_q <= S_W2;
        S_W2: state_q <= S_W3;
        S_W3: state_q <= S_W4;
        S_W4: begin
          wout_q[k_q] <= wsat;
          prev_q[k_q] <= l_cur;
          last_q[k_q] <= e_cur;
          drv_q[k_q]  <= wtr[15:0];
          if (k_q) begin
            state_q <= S_HOLD;
          end else begin
            k_q     <= 1'b1;
            state_q <= S_W0;
          end
        end
        S_HOLD: begin
          if (!out_vld_q || m_axis_tready) begin
            out_q     <= {drv_q[1], drv_q[0]};
            out_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input taken while sequencer busy");

  a_out_from_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_HOLD))
    else $error("result raised outside the hold step");

  a_mac_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_HOLD) |-> !mac_ctrl.issue)
    else $error("mac issued while idle");

  a_second_wheel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HOLD) |-> k_q)
    else $error("hold reached before right wheel");

endmodule
`default_nettype wire

>>> verif/drive_checker.sv
// checker: watches the drive controller channels, predicts wheel drives and compares
`default_nettype none
module drive_checker (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               s_axis_tvalid,
  input  wire               s_axis_tready,
  input  wire logic [63:0]  s_axis_tdata,
  input  wire logic [1:0]   s_axis_tuser,
  input  wire               m_axis_tvalid,
  input  wire               m_axis_tready,
  input  wire logic [31:0]  m_axis_tdata,
  input  wire               cfg_valid_i,
  input  wire               cfg_ready_o,
  input  wire logic [7:0]   cfg_index_i,
  input  wire logic [47:0]  cfg_data_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                drives_seen_o
);

  localparam longint One = 256;

  longint okp, okd, rkp, rkd, wkp, wki, wkd, dmax, dmin;
  logic [23:0] levels;
  longint heading_last, rate_err_last;
  longint werr_last [2];
  longint werr_prev [2];
  longint wacc [2];
  logic [31:0] drive_q [$];

  function automatic longint floor8(longint x);
    return x >>> 8;
  endfunction

  function automatic longint trunc8(longint x);
    return (x >= 0) ? (x >>> 8) : -((-x) >>> 8);
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic longint wheel_step(int k, longint err);
    longint acc;
    acc = wacc[k] + wkp * (err - werr_last[k]) + wki * err
        + wkd * (err - 2 * werr_last[k] + werr_prev[k]);
    werr_prev[k] = werr_last[k];
    werr_last[k] = err;
    if (acc > dmax * One) acc = dmax * One;
    else if (acc < dmin * One) acc = dmin * One;
    wacc[k] = acc;
    return trunc8(acc);
  endfunction

  function automatic logic [31:0] predict_drives(logic [63:0] d, logic [1:0] u);
    longint herr, yaw, lsp, rsp, tgt, aerr, diff, base, tl, tr, dl, dr;
    herr = longint'($signed(d[15:0]));
    yaw  = longint'($signed(d[31:16]));
    lsp  = longint'($signed(d[47:32]));
    rsp  = longint'($signed(d[63:48]));
    tgt = okp * herr + okd * (herr - heading_last);
    heading_last = herr;
    tgt = clip(tgt, -cddp_pkg::RateLimit * One, cddp_pkg::RateLimit * One);
    aerr = tgt - yaw * One;
    diff = floor8(rkp * aerr + rkd * (aerr - rate_err_last));
    rate_err_last = aerr;
    if (u[0]) base = levels[15:8];
    else if (u[1]) base = levels[23:16];
    else base = levels[7:0];
    tl = clip(base * One - diff, cddp_pkg::TargetLow * One, cddp_pkg::TargetHigh * One);
    tr = clip(base * One + diff, cddp_pkg::TargetLow * One, cddp_pkg::TargetHigh * One);
    dl = wheel_step(0, trunc8(tl) - lsp);
    dr = wheel_step(1, trunc8(tr) - rsp);
    return {dr[15:0], dl[15:0]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] exp_d;
    if (!rst_ni) begin
      okp = 0; okd = 0; rkp = 0; rkd = 0; wkp = 0; wki = 0; wkd = 0;
      dmax = 9999; dmin = -9999; levels = '0;
      heading_last = 0; rate_err_last = 0;
      for (int k = 0; k < 2; k++) begin
        werr_last[k] = 0; werr_prev[k] = 0; wacc[k] = 0;
      end
      drive_q.delete();
      fail_count_o <= 0;
      drives_seen_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          cddp_pkg::REG_OUTER_KP:    okp = cfg_data_i[15:0];
          cddp_pkg::REG_OUTER_KD:    okd = cfg_data_i[15:0];
          cddp_pkg::REG_RATE_KP:     rkp = cfg_data_i[15:0];
          cddp_pkg::REG_RATE_KD:     rkd = cfg_data_i[15:0];
          cddp_pkg::REG_WHEEL_GAINS: begin
            wkp = cfg_data_i[15:0]; wki = cfg_data_i[31:16]; wkd = cfg_data_i[47:32];
          end
          cddp_pkg::REG_DRIVE_MAX:   dmax = longint'($signed(cfg_data_i[15:0]));
          cddp_pkg::REG_DRIVE_MIN:   dmin = longint'($signed(cfg_data_i[15:0]));
          cddp_pkg::REG_SPEED_LVLS:  levels = cfg_data_i[23:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        drive_q.push_back(predict_drives(s_axis_tdata, s_axis_tuser));
      if (m_axis_tvalid && m_axis_tready) begin
        drives_seen_o <= drives_seen_o + 1;
        if (drive_q.size() == 0) begin
          $display("%0t: unexpected drive result %h", $time, m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_d = drive_q.pop_front();
          if (exp_d[15:0] !== m_axis_tdata[15:0] || exp_d[31:16] !== m_axis_tdata[31:16]) begin
            $display("%0t: drive mismatch expected left %0d right %0d, got left %0d right %0d",
                     $time, $signed(exp_d[15:0]), $signed(exp_d[31:16]),
                     $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]));
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= drive_q.size();
    end
  end
endmodule
`default_nettype wire

>>> verif/testbench.sv
// testbench top: drives ticks and register writes into the drive controller, gives verdict
`default_nettype none
module testbench;

  localparam int WatchLimit = 20000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  wire         s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 0;
  wire  [31:0] m_axis_tdata;
  logic        cfg_valid_i = 0;
  wire         cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;
  int          fail_count, pending, drives_seen;
  int          send_idle_pct = 0, recv_idle_pct = 0;
  bit          recv_hold = 0;
  int          idle_cycles = 0;

  cascaded_differential_drive_pid dut (.*);

  drive_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending),
    .drives_seen_o(drives_seen)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!recv_hold && $urandom_range(99) >= recv_idle_pct) m_axis_tready <= 1'b1;
    else m_axis_tready <= 1'b0;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(cddp_pkg::cfg_reg_e idx, logic [47:0] val);
    s_axis_tvalid <= 1'b0;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_tick(logic [15:0] herr, logic [15:0] yaw, logic [15:0] lsp,
                           logic [15:0] rsp, logic [1:0] flags);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {rsp, lsp, yaw, herr};
    s_axis_tuser  <= flags;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_word(int mode);
    case (mode)
      0: return 16'($signed($urandom_range(400)) - 200);
      1: return 16'($signed($urandom_range(60)) - 30);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_ticks(int n);
    int mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(9) < 7 ? $urandom_range(1) : 2;
      send_tick(rand_word(mode), rand_word(mode), rand_word(1 + (mode == 2)),
                rand_word(1 + (mode == 2)), 2'($urandom));
    end
  endtask

  task automatic random_config(bit extreme);
    write_reg(cddp_pkg::REG_OUTER_KP, extreme ? 48'hFFFF : 48'($urandom_range(2048)));
    write_reg(cddp_pkg::REG_OUTER_KD, extreme ? 48'hFFFF : 48'($urandom_range(1024)));
    write_reg(cddp_pkg::REG_RATE_KP, extreme ? 48'hFFFF : 48'($urandom_range(1024)));
    write_reg(cddp_pkg::REG_RATE_KD, extreme ? 48'hFFFF : 48'($urandom_range(512)));
    write_reg(cddp_pkg::REG_WHEEL_GAINS, extreme ? 48'hFFFF_FFFF_FFFF :
              {16'($urandom_range(256)), 16'($urandom_range(128)), 16'($urandom_range(512))});
    write_reg(cddp_pkg::REG_DRIVE_MAX, 48'($urandom));
    write_reg(cddp_pkg::REG_DRIVE_MIN, 48'($urandom));
    write_reg(cddp_pkg::REG_SPEED_LVLS, 48'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset gains, then extremes and every speed selector
    send_tick(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 2'b00);
    write_reg(cddp_pkg::REG_SPEED_LVLS, 48'h785A14);
    write_reg(cddp_pkg::REG_OUTER_KP, 48'h0200);
    write_reg(cddp_pkg::REG_OUTER_KD, 48'h0080);
    write_reg(cddp_pkg::REG_RATE_KP, 48'h0100);
    write_reg(cddp_pkg::REG_RATE_KD, 48'h0040);
    write_reg(cddp_pkg::REG_WHEEL_GAINS, 48'h0040_0020_0100);
    for (int f = 0; f < 4; f++) send_tick(16'd100, -16'sd5, 16'd3, -16'sd3, 2'(f));
    send_tick(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 2'b01);
    send_tick(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 2'b10);
    send_tick(16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 2'b11);
    drain();
    // inverted drive limits
    write_reg(cddp_pkg::REG_DRIVE_MAX, 48'hFFFF_FFFF_FF9C);
    write_reg(cddp_pkg::REG_DRIVE_MIN, 48'd100);
    write_reg(cddp_pkg::REG_WHEEL_GAINS, 48'hFFFF_FFFF_FFFF);
    for (int i = 0; i < 6; i++) send_tick(rand_word(2), rand_word(2), rand_word(2),
                                          rand_word(2), 2'(i));
    drain();
    write_reg(cddp_pkg::REG_DRIVE_MAX, 48'h7FFF);
    write_reg(cddp_pkg::REG_DRIVE_MIN, 48'h8000);
    for (int i = 0; i < 8; i++) send_tick(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 2'(i));
    drain();

    // random phases with different idling
    send_idle_pct = 23; recv_idle_pct = 84;
    random_config(0);
    random_ticks(518);
    drain();
    send_idle_pct = 84; recv_idle_pct = 23;
    random_config(1);
    random_ticks(120);
    drain();
    random_config(0);
    random_ticks(150);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    random_config(0);
    fork
      begin
        recv_hold = 1;
        repeat (300) @(posedge clk_i);
        recv_hold = 0;
      end
      random_ticks(40);
    join
    random_ticks(200);
    drain();
    write_reg(cddp_pkg::REG_DRIVE_MAX, 48'd0);
    write_reg(cddp_pkg::REG_DRIVE_MIN, 48'd0);
    random_ticks(100);
    drain();

    $display("covered %0d drive results over several gain and limit settings,", drives_seen);
    $display("including inverted and full-range limits, all speed selectors and stalls");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
